>>> rtl/core/tnh_pkg.sv
// shared constants, payload types and helpers for the ternary n-gram histogram
`default_nettype none

package tnh_pkg;

  // longest run that gets a histogram, and the width of one counter
  localparam int MAX_ORDER   = 5;
  localparam int COUNT_WIDTH = 32;

  // fixed field widths of the channels
  localparam int CMD_W       = 2;
  localparam int DIGIT_W     = 2;
  localparam int ORDER_W     = 3;
  localparam int INDEX_W     = 8;
  localparam int COUNT_OUT_W = 32;

  function automatic int unsigned pow3(input int unsigned k);
    int unsigned p;
    p = 1;
    for (int unsigned i = 0; i < k; i++) begin
      p = p * 3;
    end
    return p;
  endfunction

  localparam int unsigned POW3_MAX = pow3(MAX_ORDER);
  // bits of a run index at the longest order
  localparam int IDX_W  = $clog2(POW3_MAX);
  // symbols kept from earlier in the line
  localparam int HIST_N = (MAX_ORDER > 1) ? MAX_ORDER - 1 : 1;
  localparam int FILL_W = $clog2(MAX_ORDER + 1);
  localparam int EXT_W  = (COUNT_WIDTH > COUNT_OUT_W) ? COUNT_WIDTH : COUNT_OUT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_EOL  = 2'd1,
    CMD_READ = 2'd2
  } tnh_cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [DIGIT_W-1:0] digit;
    logic [ORDER_W-1:0] read_order;
    logic [INDEX_W-1:0] read_index;
  } tnh_in_t;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] count;
    logic                   bad_index;
  } tnh_out_t;

  // counters wider than the result field report all ones once they pass it
  function automatic logic [COUNT_OUT_W-1:0] clip_count(input logic [COUNT_WIDTH-1:0] c);
    logic [EXT_W-1:0] w;
    w = EXT_W'(c);
    if (w > EXT_W'({COUNT_OUT_W{1'b1}})) begin
      return '1;
    end
    return w[COUNT_OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ternary_ngram_histogram.sv
// top level: run histograms of ternary symbols over a text line
//
// input channel (in_valid_i / in_stall_o / in_data_i) takes one command beat:
//   push a symbol, end the line, or read one counter. a beat is taken when
//   valid is high and stall is low.
// output channel (out_valid_o / out_stall_i / out_data_o) carries one beat
//   per read command: the counter value and a bad-index flag. push and end of
//   line produce nothing.
// throughput is one beat per cycle for any mix of commands while the
//   receiver does not stall and no clearing pass runs. every order has its own
//   counter memory, so a push does all of its read-modify-writes in one
//   pass; back-to-back hits on one counter are forwarded from the write.
// a read beat passes the input register, the memory read register and the
//   output register before its result shows.
// when the receiver stalls, a waiting result holds in the output register and
//   the pipe keeps moving until a second read result waits in stage 2 and
//   stage 1 holds a beat too; only then does in_stall_o rise.
// reset clears the line history; a clearing pass then zeroes one counter
//   address per cycle in all banks, and in_stall_o stays high until it is done.
`default_nettype none

module ternary_ngram_histogram
  import tnh_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tnh_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tnh_out_t out_data_o
);

  // line history: slot 0 holds the newest symbol
  logic [DIGIT_W-1:0] hist_q [HIST_N];
  logic [DIGIT_W-1:0] hist_d [HIST_N];
  logic [FILL_W-1:0]  fill_q, fill_d, fill_inc;

  // pipe control
  logic in_acc, in_rdy, s1_go, s2_go, out_free;
  logic push_ok;

  // clearing pass after reset
  logic             clr_busy_q, clr_busy_d;
  logic [IDX_W-1:0] clr_addr_q, clr_addr_d;

  // stage 1: command registered, memory addresses presented
  logic                 s1_valid_q;
  logic                 s1_read_q, s1_read_d;
  logic                 s1_bad_q, s1_bad_d;
  logic [MAX_ORDER-1:0] s1_inc_q, s1_inc_d;
  logic [ORDER_W-1:0]   s1_order_q;
  logic [IDX_W-1:0]     s1_addr_q [MAX_ORDER];
  logic [IDX_W-1:0]     s1_addr_d [MAX_ORDER];

  // stage 2: counter values available, increments written back
  logic                 s2_valid_q;
  logic                 s2_read_q;
  logic                 s2_bad_q;
  logic [MAX_ORDER-1:0] s2_inc_q;
  logic [ORDER_W-1:0]   s2_order_q;
  logic [IDX_W-1:0]     s2_addr_q [MAX_ORDER];

  logic [COUNT_WIDTH-1:0] bank_val [MAX_ORDER];
  logic [MAX_ORDER-1:0]   bank_we;
  logic [COUNT_WIDTH-1:0] sel_val;

  // result register
  logic     out_valid_q;
  tnh_out_t out_data_q;

  // ---------------------------------------------------------------------------
  // handshake: the result register frees stage 2, stage 2 frees stage 1
  // ---------------------------------------------------------------------------
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_go      = !s2_valid_q || !s2_read_q || out_free;
  assign s1_go      = !s1_valid_q || s2_go;
  assign in_rdy     = s1_go && !clr_busy_q;
  assign in_stall_o = !in_rdy;
  assign in_acc     = in_valid_i && in_rdy;

  // clearing pass walks every address of the largest bank once
  assign clr_addr_d = clr_addr_q + 1'b1;
  assign clr_busy_d = clr_busy_q && (clr_addr_q != IDX_W'(POW3_MAX - 1));

  // ---------------------------------------------------------------------------
  // decode: history update, run indexes per order, read checks
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [IDX_W-1:0] acc;
    push_ok  = (in_data_i.cmd == CMD_PUSH) && (in_data_i.digit < 2'd3);
    fill_inc = (fill_q == FILL_W'(MAX_ORDER)) ? fill_q : fill_q + 1'b1;

    hist_d = hist_q;
    fill_d = fill_q;
    if (in_acc) begin
      case (in_data_i.cmd)
        CMD_PUSH: begin
          // a digit of three is dropped without touching the line
          if (push_ok) begin
            hist_d[0] = in_data_i.digit;
            for (int j = 1; j < HIST_N; j++) begin
              hist_d[j] = hist_q[j-1];
            end
            fill_d = fill_inc;
          end
        end
        CMD_EOL: begin
          for (int j = 0; j < HIST_N; j++) begin
            hist_d[j] = '0;
          end
          fill_d = '0;
        end
        default: begin
        end
      endcase
    end

    s1_read_d = (in_data_i.cmd == CMD_READ);

    // index check, order out of range counts as bad too
    s1_bad_d = 1'b1;
    for (int g = 0; g < MAX_ORDER; g++) begin
      if ((32'(in_data_i.read_order) == g + 1) &&
          (32'(in_data_i.read_index) < pow3(g + 1))) begin
        s1_bad_d = 1'b0;
      end
    end

    // base-3 value of the last g+1 symbols, oldest first
    for (int g = 0; g < MAX_ORDER; g++) begin
      acc = '0;
      for (int j = HIST_N - 1; j >= 0; j--) begin
        if (j < g) begin
          acc = IDX_W'(acc * 3) + IDX_W'(hist_q[j]);
        end
      end
      if (s1_read_d) begin
        s1_addr_d[g] = IDX_W'(in_data_i.read_index);
      end else begin
        s1_addr_d[g] = IDX_W'(acc * 3) + IDX_W'(in_data_i.digit);
      end
      s1_inc_d[g] = push_ok && (fill_inc >= FILL_W'(g + 1));
    end
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q      <= '{default: '0};
      fill_q      <= '0;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      hist_q <= hist_d;
      fill_q <= fill_d;
      clr_busy_q <= clr_busy_d;
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_d;
      end
      if (s1_go) begin
        s1_valid_q <= in_acc;
      end
      if (s2_go) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q && s2_read_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_read_q  <= s1_read_d;
      s1_bad_q   <= s1_bad_d;
      s1_inc_q   <= s1_inc_d;
      s1_order_q <= in_data_i.read_order;
      s1_addr_q  <= s1_addr_d;
    end
    if (s2_go) begin
      s2_read_q  <= s1_read_q;
      s2_bad_q   <= s1_bad_q;
      s2_inc_q   <= s1_inc_q;
      s2_order_q <= s1_order_q;
      s2_addr_q  <= s1_addr_q;
    end
    if (out_free && s2_valid_q && s2_read_q) begin
      out_data_q.count     <= s2_bad_q ? '0 : clip_count(sel_val);
      out_data_q.bad_index <= s2_bad_q;
    end
  end

  // ---------------------------------------------------------------------------
  // one counter bank per order: read in stage 1, increment and write in stage 2
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < MAX_ORDER; g++) begin : g_bank
    localparam int Depth = int'(pow3(g + 1));
    localparam int Aw    = $clog2(Depth);

    logic                   fwd_q;
    logic [COUNT_WIDTH-1:0] fwd_val_q;
    logic [COUNT_WIDTH-1:0] ram_rd, cur, nxt;
    logic [Aw-1:0]          raddr, waddr;
    logic                   clr_we;
    logic                   ram_we;
    logic [Aw-1:0]          ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;

    assign raddr = s1_addr_q[g][Aw-1:0];
    assign waddr = s2_addr_q[g][Aw-1:0];

    // same-address write from the beat ahead is forwarded
    assign cur = fwd_q ? fwd_val_q : ram_rd;
    // saturating increment
    assign nxt = (&cur) ? cur : cur + 1'b1;

    assign bank_we[g]  = s2_valid_q && s2_inc_q[g] && s2_go;
    assign bank_val[g] = cur;

    // the clearing pass owns the write port until it is done
    assign clr_we    = clr_busy_q && (clr_addr_q < IDX_W'(Depth));
    assign ram_we    = bank_we[g] || clr_we;
    assign ram_waddr = clr_busy_q ? clr_addr_q[Aw-1:0] : waddr;
    assign ram_wdata = clr_busy_q ? '0 : nxt;

    tnh_ram #(
      .Depth(Depth),
      .Width(COUNT_WIDTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we),
      .waddr_i(ram_waddr),
      .wdata_i(ram_wdata),
      .re_i   (s2_go),
      .raddr_i(raddr),
      .rdata_o(ram_rd)
    );

    always_ff @(posedge clk_i) begin
      if (s2_go) begin
        fwd_q     <= bank_we[g] && (waddr == raddr);
        fwd_val_q <= nxt;
      end
    end
  end

  // pick the histogram that the read asked for
  always_comb begin
    sel_val = '0;
    for (int g = 0; g < MAX_ORDER; g++) begin
      if (32'(s2_order_q) == g + 1) begin
        sel_val = bank_val[g];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_read_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_read_q && s2_go) |=> out_valid_o)
    else $error("read leaving stage 2 did not load the result register");

  a_bad_means_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.bad_index) |-> (out_data_o.count == '0))
    else $error("bad index result carries a nonzero count");

  a_fill_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(MAX_ORDER))
    else $error("line fill above the longest order");

  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_go) |=> s1_valid_q)
    else $error("stage 1 item lost while stage 2 was blocked");

  a_write_only_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|bank_we) |-> (s2_valid_q && !s2_read_q))
    else $error("counter write from a non-push beat");

  a_stall_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> in_stall_o)
    else $error("input beat taken during the clearing pass");

endmodule

`default_nettype wire

>>> rtl/core/tnh_ram.sv
// single-port-write, registered-read counter memory
`default_nettype none

module tnh_ram #(
  parameter int Depth = 3,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> verif/testbench.sv
// testbench for the ternary n-gram histogram: directed and random command beats, scored in order
`default_nettype none

module testbench
  import tnh_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // codes the package leaves unnamed: the spare command and the symbol with no meaning
  localparam logic [CMD_W-1:0]   CMD_SPARE  = 2'd3;
  localparam logic [DIGIT_W-1:0] DIGIT_VOID = 2'd3;

  localparam int unsigned      NUM_COUNTERS = (POW3_MAX * 3 - 3) / 2;
  localparam longint unsigned  COUNT_TOP    = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_WIDTH);
  localparam int               MAX_WAIT     = 12;
  localparam int               IN_W         = $bits(tnh_in_t);
  // slowest run is about 1900 beats; leave lots of room
  localparam int               CYCLE_LIMIT  = 500000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  tnh_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  tnh_out_t out_data;

  // idling switches for the sender and the receiver
  bit send_idle_en = 1'b1;
  bit recv_idle_en = 1'b1;

  int errors = 0;
  int cycles = 0;
  int recv_wait = 0;

  // histogram mirror: line history, fill and every counter
  int unsigned     line_digits;
  int unsigned     line_len;
  longint unsigned run_count [NUM_COUNTERS];

  // results owed by read beats already taken, oldest first
  tnh_out_t pending_reads [$];

  ternary_ngram_histogram i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // number of distinct runs of length k
  function automatic int unsigned ternary_span(input int unsigned k);
    int unsigned p;
    p = 1;
    repeat (k) p = p * 3;
    return p;
  endfunction

  // advance the histogram mirror by one taken beat; reads queue their result
  function automatic void update_histogram(input tnh_in_t b);
    int unsigned     fill;
    int unsigned     v;
    int unsigned     p;
    int unsigned     slot;
    longint unsigned c;
    tnh_out_t        r;
    case (b.cmd)
      CMD_PUSH: begin
        // the void symbol leaves everything as it was
        if (b.digit != DIGIT_VOID) begin
          fill = (line_len + 1 > MAX_ORDER) ? MAX_ORDER : line_len + 1;
          v = line_digits * 3 + b.digit;
          // every run ending at this symbol, up to the line fill, gets a hit
          for (int unsigned k = 1; k <= fill; k++) begin
            p = ternary_span(k);
            slot = (p - 3) / 2 + (v % p);
            if (run_count[slot] < COUNT_TOP) run_count[slot]++;
          end
          line_digits = v % ternary_span(MAX_ORDER - 1);
          line_len = fill;
        end
      end
      CMD_EOL: begin
        line_digits = 0;
        line_len = 0;
      end
      CMD_READ: begin
        c = 0;
        r.bad_index = 1'b1;
        if (b.read_order >= 1 && b.read_order <= MAX_ORDER) begin
          p = ternary_span(b.read_order);
          if (b.read_index < p) begin
            c = run_count[(p - 3) / 2 + b.read_index];
            r.bad_index = 1'b0;
          end
        end
        if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
        r.count = c[COUNT_OUT_W-1:0];
        pending_reads.push_back(r);
      end
      default: begin
        // spare command: ignored
      end
    endcase
  endfunction

  // one beat with every field random, then the command and symbol forced
  function automatic tnh_in_t make_beat(input logic [CMD_W-1:0] cmd,
                                        input logic [DIGIT_W-1:0] digit);
    tnh_in_t b;
    b = tnh_in_t'(IN_W'($urandom()));
    b.cmd = cmd;
    b.digit = digit;
    return b;
  endfunction

  function automatic tnh_in_t read_beat(input int unsigned order, input int unsigned index);
    tnh_in_t b;
    b = make_beat(CMD_READ, 2'($urandom()));
    b.read_order = ORDER_W'(order);
    b.read_index = INDEX_W'(index);
    return b;
  endfunction

  // drive one beat after a random gap and hold it until taken
  task automatic send_beat(input tnh_in_t b);
    int gap;
    gap = send_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    // taken at this edge
    update_histogram(b);
  endtask

  // receiver: score each taken beat, then stall for a random stretch
  always @(posedge clk_i) begin
    if (out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: result beat with no read waiting, count %0d bad_index %0b",
                 $time, out_data.count, out_data.bad_index);
        errors++;
      end else begin
        if (out_data.count !== pending_reads[0].count) begin
          $display("%0t: count mismatch, expected %0d actual %0d",
                   $time, pending_reads[0].count, out_data.count);
          errors++;
        end
        if (out_data.bad_index !== pending_reads[0].bad_index) begin
          $display("%0t: bad_index mismatch, expected %0b actual %0b",
                   $time, pending_reads[0].bad_index, out_data.bad_index);
          errors++;
        end
        void'(pending_reads.pop_front());
      end
      recv_wait = recv_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
    end
    if (recv_wait > 0) begin
      out_stall <= 1'b1;
      recv_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // all counters read zero after reset; edges of order and index
  task automatic test_reset_state();
    send_beat(read_beat(1, 0));
    send_beat(read_beat(MAX_ORDER, POW3_MAX - 1));
    send_beat(read_beat(MAX_ORDER, POW3_MAX));   // index just past the order
    send_beat(read_beat(1, 3));
    send_beat(read_beat(0, 0));                  // order zero
    send_beat(read_beat(7, 255));                // order above the top, index all ones
  endtask

  // one full window, the ignored beats, then a fresh line
  task automatic test_directed_runs();
    send_beat(make_beat(CMD_PUSH, 2'd2));
    send_beat(make_beat(CMD_PUSH, 2'd1));
    send_beat(make_beat(CMD_PUSH, 2'd0));
    send_beat(make_beat(CMD_PUSH, 2'd2));
    send_beat(make_beat(CMD_PUSH, 2'd2));
    send_beat(make_beat(CMD_PUSH, DIGIT_VOID));  // void symbol must not touch the history
    send_beat(make_beat(CMD_SPARE, 2'd1));       // spare command does nothing
    send_beat(read_beat(5, 197));                // run 2,1,0,2,2
    send_beat(read_beat(2, 8));                  // run 2,2
    send_beat(make_beat(CMD_EOL, 2'd0));
    send_beat(make_beat(CMD_PUSH, 2'd2));
    // a run spanning the line end must not have been counted again
    send_beat(read_beat(2, 8));
    send_beat(read_beat(1, 2));
  endtask

  // lines of random symbols with reads mixed in, plus some noise
  task automatic test_random_lines(input int n_beats);
    int sent;
    int len;
    int r;
    int unsigned ord;
    sent = 0;
    while (sent < n_beats) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          send_beat(make_beat(CMD_PUSH, 2'($urandom_range(0, 2))));
          sent++;
        end else if (r < 88) begin
          ord = $urandom_range(1, MAX_ORDER);
          send_beat(read_beat(ord, $urandom_range(0, ternary_span(ord) - 1)));
          sent++;
        end else if (r < 93) begin
          send_beat(read_beat($urandom_range(0, 7), $urandom_range(0, 255)));
          sent++;
        end else if (r < 96) begin
          send_beat(make_beat(CMD_PUSH, DIGIT_VOID));
        end else if (r < 98) begin
          send_beat(make_beat(CMD_SPARE, 2'($urandom())));
        end else begin
          // line broken early
          send_beat(make_beat(CMD_EOL, 2'($urandom())));
          sent++;
        end
      end
      send_beat(make_beat(CMD_EOL, 2'($urandom())));
      sent++;
    end
  endtask

  // receiver stalls while the sender never pauses, so the input side backs up
  task automatic test_back_pressure(input int n_beats);
    send_idle_en = 1'b0;
    recv_idle_en = 1'b1;
    test_random_lines(n_beats);
  endtask

  initial begin
    line_digits = 0;
    line_len = 0;
    foreach (run_count[i]) run_count[i] = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_directed_runs();

    // both sides idling
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    test_random_lines(500);
    // full rate on both sides
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    test_random_lines(450);
    // only the sender pauses
    send_idle_en = 1'b1;
    recv_idle_en = 1'b0;
    test_random_lines(450);
    test_back_pressure(450);

    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    // wait past the pipe depth to catch stray beats
    repeat (10) @(posedge clk_i);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/tnh_pkg.sv
rtl/core/tnh_ram.sv
rtl/core/ternary_ngram_histogram.sv
verif/testbench.sv
